[hdl/bounded_array_list_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded array list core
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_CORE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BAL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bal_pkg.sv]
// ----------------------------------------------------------------------------
// bal_pkg
// Types and constants shared by the bounded array list core.
// ----------------------------------------------------------------------------
package bal_pkg;

	localparam int WORD_W  = 32;
	localparam int IDX_W   = 6;   // cell index, covers the largest build
	localparam int CMP_W   = 7;   // width for count and capacity compares
	localparam int CAP_W   = 6;
	localparam int COUNT_W = 6;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT     = 3'd4,
		OP_READ       = 3'd5,
		OP_WRITE      = 3'd6
	} op_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic        [2:0]        opcode;
		logic signed [7:0]        position;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  read_value;
		logic        [COUNT_W-1:0] entry_count;
		logic        [1:0]         status;
	} res_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INS,    // shift up over (lo, hi], load word at lo
		CM_DEL,    // shift down over [lo, hi)
		CM_WR      // load word at lo
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic [IDX_W-1:0]   lo;
		logic [IDX_W-1:0]   hi;
		logic [WORD_W-1:0]  word;
	} cell_ctrl_t;

endpackage

[hdl/bal_cell.sv]
// ----------------------------------------------------------------------------
// bal_cell
// One list slot: holds a word and takes its neighbour's on a shift.
// ----------------------------------------------------------------------------
module bal_cell import bal_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctrl_t          ctrl,
	input  logic [WORD_W-1:0]   left,
	input  logic [WORD_W-1:0]   right,
	output logic [WORD_W-1:0]   data
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctrl.mode)
			CM_INS: begin
				if (MY_IDX == ctrl.lo)
					data_d = ctrl.word;
				else if (MY_IDX > ctrl.lo && MY_IDX <= ctrl.hi)
					data_d = left;
			end
			CM_DEL: begin
				if (MY_IDX >= ctrl.lo && MY_IDX < ctrl.hi)
					data_d = right;
			end
			CM_WR: begin
				if (MY_IDX == ctrl.lo)
					data_d = ctrl.word;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= data_d;
		end
	end

	assign data = data_q;

endmodule

[hdl/bal_ctrl.sv]
// ----------------------------------------------------------------------------
// bal_ctrl
// Command decode, entry count, capacity register and result register.
// ----------------------------------------------------------------------------
`include "bounded_array_list_core_defines.svh"

module bal_ctrl import bal_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cmd_t               cmd,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_data,
	input  logic [WORD_W-1:0]  rd_word,
	output logic [IDX_W-1:0]   rd_idx,
	output cell_ctrl_t         cell_ctrl,
	output logic               done,
	output res_t               result
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic             done_q;
	res_t             res_q;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] count_c;
	logic [CMP_W-1:0] pos_c;
	logic             full;
	logic             empty;
	logic             pos_in_cap;
	logic             pos_in_list;
	logic [1:0]       st;
	logic             rd_en;
	cell_ctrl_t       sc;

	assign cap_eff     = (CMP_W'(cap_q) > DEPTH_C) ? DEPTH_C : CMP_W'(cap_q);
	assign count_c     = CMP_W'(count_q);
	assign pos_c       = cmd.position[6:0];
	assign full        = count_c >= cap_eff;
	assign empty       = count_q == '0;
	assign pos_in_cap  = !cmd.position[7] && pos_c < cap_eff;
	assign pos_in_list = !cmd.position[7] && pos_c < count_c;
	assign rd_idx      = IDX_W'(pos_c);

	always_comb begin
		sc.mode = CM_HOLD;
		sc.lo   = '0;
		sc.hi   = '0;
		sc.word = cmd.value;
		count_d = count_q;
		st      = ST_DONE;
		rd_en   = 1'b0;
		unique case (op_t'(cmd.opcode))
			OP_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					sc.mode = CM_INS;
					sc.hi   = IDX_W'(count_q);
					count_d = count_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					sc.mode = CM_INS;
					sc.lo   = IDX_W'(count_q);
					sc.hi   = IDX_W'(count_q);
					count_d = count_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					sc.mode = CM_DEL;
					sc.hi   = IDX_W'(count_q - CW'(1));
					count_d = count_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty)
					st = ST_EMPTY;
				else
					count_d = count_q - CW'(1);
			end
			OP_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					// an invalid position appends
					sc.mode = CM_INS;
					sc.lo   = pos_in_list ? IDX_W'(pos_c) : IDX_W'(count_q);
					sc.hi   = IDX_W'(count_q);
					count_d = count_q + CW'(1);
				end
			end
			OP_READ: begin
				if (pos_in_cap)
					rd_en = 1'b1;
				else
					st = ST_RANGE;
			end
			OP_WRITE: begin
				if (pos_in_cap) begin
					sc.mode = CM_WR;
					sc.lo   = IDX_W'(pos_c);
				end else begin
					st = ST_RANGE;
				end
			end
			default: st = ST_DONE;
		endcase
	end

	always_comb begin
		cell_ctrl = sc;
		if (!start)
			cell_ctrl.mode = CM_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= start;
			if (cfg_we)
				cap_q <= cfg_data;
			if (start)
				count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			res_q.read_value  <= rd_en ? rd_word : '0;
			res_q.entry_count <= COUNT_W'(count_d);
			res_q.status      <= st;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`BAL_ASSERT_NEXT(a_word_per_cmd, start, done, "accepted command gave no result word")
	`BAL_ASSERT_NEXT(a_no_spurious, !start, !done, "result word without a command")
	`BAL_ASSERT_NOW(a_count_bound, 1'b1, count_c <= DEPTH_C, "entry count beyond depth")
	`BAL_ASSERT_NOW(a_full_flag, done && res_q.status == ST_FULL, count_c >= cap_eff, "full flagged below capacity")
	`BAL_ASSERT_NOW(a_rd_zero, done && res_q.read_value != '0, res_q.status == ST_DONE, "failed command returned data")

endmodule

[hdl/bounded_array_list_core.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_core
// The result word is strobed on done in the cycle after start.
// Throughput: one command per cycle; busy stays low, the cell row updates at once.
// Reset: asynchronous, clears every slot and the count, capacity returns to 20.
// The receiver cannot stall: each result word is shown for one cycle only.
// ----------------------------------------------------------------------------
module bounded_array_list_core import bal_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_data,
	output logic              done,
	output res_t              result
);

	localparam int AW = $clog2(DEPTH);

	logic [WORD_W-1:0] cell_word [DEPTH];
	cell_ctrl_t        cell_ctrl;
	logic [IDX_W-1:0]  rd_idx;
	logic [WORD_W-1:0] rd_word;

	// every command finishes in the cycle it is taken
	assign busy    = 1'b0;
	assign rd_word = cell_word[rd_idx[AW-1:0]];

	bal_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start && !busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rd_word   (rd_word),
		.rd_idx    (rd_idx),
		.cell_ctrl (cell_ctrl),
		.done      (done),
		.result    (result)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = cell_word[i+1];
		end

		bal_cell #(
			.IDX (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.left   (left),
			.right  (right),
			.data   (cell_word[i])
		);
	end

endmodule
